// ===== src/pfr_pkg.sv =====
// Shared types, codes and helper functions of the polynomial root finder.
package pfr_pkg;

    localparam int W = 64;

    typedef logic [1:0] status_t;
    localparam status_t STAT_CONVERGED = 2'd0;
    localparam status_t STAT_LIMIT     = 2'd1;
    localparam status_t STAT_NO_ROOTS  = 2'd2;
    localparam status_t STAT_BAD_BOUND = 2'd3;

    localparam logic [2:0] REG_COEF_X4   = 3'd0;
    localparam logic [2:0] REG_COEF_X0   = 3'd4;
    localparam logic [2:0] REG_TOLERANCE = 3'd5;
    localparam logic [2:0] REG_STEP      = 3'd6;
    localparam logic [2:0] REG_ITER_LIM  = 3'd7;

    localparam logic signed [W-1:0] SAT_POS = 64'sh4000_0000_0000_0000;
    localparam logic signed [W-1:0] SAT_NEG = -64'sh4000_0000_0000_0000;

    // Saturates a wide signed value to the 32-bit range.
    function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fff_ffff;
        else if (v < -66'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    // Magnitude of a signed 64-bit value that stays within +-2^62.
    function automatic logic [W-1:0] mag64(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

endpackage

// ===== src/polynomial_false_position_root_finder_unit.sv =====
// Top level of the polynomial root finder: sequencer, shared multiplier, result buffer.
//
// Usage: load the coefficients, tolerance, scan step and iteration limit through
// the write port (cfg_we, cfg_addr, cfg_wdata) while the block is idle. A request
// on the slave stream with tdata bit 0 set runs one full search; a request with
// bit 0 clear is taken and dropped. s_tready is high only while idle.
// The block derives the bound xmax with two divisions and a square root, scans
// [-xmax, xmax] and refines each bracket by false position. Each polynomial
// evaluation runs on the one 32x32 multiplier; each refinement step costs one
// evaluation, the operand scaling with any halving of the bracket weights, and
// one division; a search's length grows with its scan points and refinement steps.
// Results (one per root, at most DEGREE, or one status result) are held in a
// small buffer and sent on the master stream after the search ends; m_tlast
// marks the final result. A stalled receiver simply holds the block in its
// output phase; nothing is lost. Reset loads the default configuration and
// returns the block to idle with no result pending.
module polynomial_false_position_root_finder_unit #(
    parameter int DEGREE    = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] root_value, [41:32] iteration_count
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import pfr_pkg::*;

    localparam int NW = $clog2(DEGREE + 1);
    localparam int IW = $clog2(DEGREE);
    localparam int PW = $clog2(DEGREE);
    localparam logic [W-1:0] PH_MAX = W'(1) << (30 + FRAC_BITS);
    localparam logic [W:0]   HALF_LIM = (W+1)'(1) << 42;

    typedef enum logic [20:0] {
        S_IDLE  = 21'd1 << 0,
        S_Q1    = 21'd1 << 1,
        S_Q2    = 21'd1 << 2,
        S_SQMUL = 21'd1 << 3,
        S_RAD   = 21'd1 << 4,
        S_SQRT  = 21'd1 << 5,
        S_SCAN  = 21'd1 << 6,
        S_PMH   = 21'd1 << 7,
        S_PML   = 21'd1 << 8,
        S_PADD  = 21'd1 << 9,
        S_F1    = 21'd1 << 10,
        S_F2    = 21'd1 << 11,
        S_RHALF = 21'd1 << 12,
        S_RML   = 21'd1 << 13,
        S_RMH   = 21'd1 << 14,
        S_RDIVS = 21'd1 << 15,
        S_RDIV  = 21'd1 << 16,
        S_RTEST = 21'd1 << 17,
        S_FIN   = 21'd1 << 18,
        S_EMIT  = 21'd1 << 19,
        S_ERR   = 21'd1 << 20
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;

    logic signed [31:0] coef_reg [0:4];
    logic [16:0]        tol_reg;
    logic [20:0]        step_reg;
    logic [9:0]         lim_reg;

    logic signed [31:0] q1_reg, q1_next, q2_reg, q2_next;
    logic signed [33:0] limit_reg, limit_next, pos_reg, pos_next;
    logic signed [31:0] x1_reg, x1_next, x2_reg, x2_next, x0_reg, x0_next;
    logic signed [31:0] px_reg, px_next, prev_reg, prev_next;
    logic signed [W-1:0] f1_reg, f1_next, f2_reg, f2_next, acc_reg, acc_next;
    logic [W-1:0]       ha_reg, ha_next, hb_reg, hb_next, tmp_reg, tmp_next;
    logic [W-1:0]       prod_reg;
    logic [PW-1:0]      p_reg, p_next;
    logic [9:0]         i_reg, i_next;
    logic               have_prev_reg, have_prev_next;
    logic [NW-1:0]      n_reg, n_next;
    logic [IW-1:0]      k_reg, k_next;

    logic signed [31:0] res_root_reg [0:DEGREE-1];
    logic [9:0]         res_cnt_reg  [0:DEGREE-1];
    status_t            res_st_reg   [0:DEGREE-1];
    logic               rec_en;
    logic [IW-1:0]      rec_idx;
    logic signed [31:0] rec_root;
    logic [9:0]         rec_cnt;
    status_t            rec_st;

    logic [31:0]   mul_a, mul_b;
    logic [W-1:0]  mul_p;
    logic          div_start, div_done, sq_start, sq_done;
    logic [W-1:0]  div_num, div_den, div_quo, sq_val, sq_root;

    logic signed [31:0] lead, c_hi1, c_hi2, coef_p;
    logic [W-1:0]       acc_mag;
    logic [W-1:0]       step_eff;
    logic [W:0]         r_raw, r_sat;
    logic signed [W+1:0] r_signed, poly_sum;
    logic signed [W+1:0] qs, rad;
    logic [W:0]         hsum;
    logic [31:0]        w_span;
    logic signed [32:0] dx;
    logic [32:0]        dx_mag;
    logic               conv, f0_opp;

    assign lead   = coef_reg[DEGREE];
    assign c_hi1  = coef_reg[DEGREE-1];
    assign c_hi2  = coef_reg[DEGREE-2];
    assign coef_p = coef_reg[3'(p_reg)];
    assign acc_mag = mag64(acc_reg);
    assign step_eff = (step_reg == 21'd0) ? W'(1) : W'(step_reg);
    assign mul_p  = mul_a * mul_b;
    assign hsum   = {1'b0, ha_reg} + {1'b0, hb_reg};
    assign w_span = 32'(x2_reg - x1_reg);

    pfr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    pfr_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .val   (sq_val),
        .done  (sq_done),
        .root  (sq_root)
    );

    // Horner step: truncated magnitude product, saturated, plus the next coefficient.
    always_comb
    begin
        r_raw = {1'b0, tmp_reg << (32 - FRAC_BITS)} + {1'b0, prod_reg >> FRAC_BITS};
        if (tmp_reg > PH_MAX || r_raw > (W+1)'(SAT_POS))
            r_sat = (W+1)'(SAT_POS);
        else
            r_sat = r_raw;
        r_signed = (acc_reg[W-1] != px_reg[31]) ? -$signed({1'b0, r_sat})
                                                :  $signed({1'b0, r_sat});
        poly_sum = r_signed + (W+2)'(coef_p);
    end

    always_comb
    begin
        qs  = (W+2)'(0);
        rad = $signed({2'b00, prod_reg >> FRAC_BITS}) - ((W+2)'(q2_reg) <<< 1);
        if (div_done)
            qs = ((state_reg == S_Q1 ? c_hi1[31] : c_hi2[31]) != lead[31])
                 ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
        dx     = 33'(x0_reg) - 33'(prev_reg);
        dx_mag = dx[32] ? 33'(-dx) : 33'(dx);
        conv   = (mag64(acc_reg) < W'(tol_reg)) || (have_prev_reg && dx_mag < 33'(tol_reg));
        f0_opp = (acc_reg[W-1] && f1_reg > 0) || (acc_reg > 0 && f1_reg[W-1]);
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        q1_next        = q1_reg;
        q2_next        = q2_reg;
        limit_next     = limit_reg;
        pos_next       = pos_reg;
        x1_next        = x1_reg;
        x2_next        = x2_reg;
        x0_next        = x0_reg;
        px_next        = px_reg;
        prev_next      = prev_reg;
        f1_next        = f1_reg;
        f2_next        = f2_reg;
        acc_next       = acc_reg;
        ha_next        = ha_reg;
        hb_next        = hb_reg;
        tmp_next       = tmp_reg;
        p_next         = p_reg;
        i_next         = i_reg;
        have_prev_next = have_prev_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = '0;
        sq_start       = 1'b0;
        sq_val         = '0;
        rec_en         = 1'b0;
        rec_idx        = n_reg[IW-1:0];
        rec_root       = x0_reg;
        rec_cnt        = i_reg;
        rec_st         = STAT_CONVERGED;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tdata[0])
                begin
                    n_next = '0;
                    k_next = '0;
                    if (lead == 32'sd0)
                        state_next = S_ERR;
                    else
                    begin
                        div_start  = 1'b1;
                        div_num    = W'(mag64(W'(c_hi1))) << FRAC_BITS;
                        div_den    = mag64(W'(lead));
                        state_next = S_Q1;
                    end
                end
            end
            S_Q1:
            begin
                if (div_done)
                begin
                    q1_next    = clamp32(qs);
                    div_start  = 1'b1;
                    div_num    = W'(mag64(W'(c_hi2))) << FRAC_BITS;
                    div_den    = mag64(W'(lead));
                    state_next = S_Q2;
                end
            end
            S_Q2:
            begin
                if (div_done)
                begin
                    q2_next    = clamp32(qs);
                    state_next = S_SQMUL;
                end
            end
            S_SQMUL:
            begin
                mul_a      = 32'(mag64(W'(q1_reg)));
                mul_b      = 32'(mag64(W'(q1_reg)));
                state_next = S_RAD;
            end
            S_RAD:
            begin
                if (rad[W+1])
                    state_next = S_ERR;
                else
                begin
                    sq_start   = 1'b1;
                    sq_val     = W'(rad) << FRAC_BITS;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sq_done)
                begin
                    limit_next = (sq_root > W'(32'h7fff_ffff)) ? 34'sh07fff_ffff
                                                               : $signed(34'(sq_root));
                    pos_next   = -((sq_root > W'(32'h7fff_ffff)) ? 34'sh07fff_ffff
                                                                 : $signed(34'(sq_root)));
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (limit_reg > pos_reg && n_reg < NW'(DEGREE))
                begin
                    x1_next    = pos_reg[31:0];
                    x2_next    = clamp32((W+2)'(pos_reg) + $signed({2'b00, step_eff}));
                    px_next    = pos_reg[31:0];
                    acc_next   = W'(lead);
                    p_next     = PW'(DEGREE - 1);
                    ret_next   = S_F1;
                    state_next = S_PMH;
                end
                else
                    state_next = S_FIN;
            end
            S_PMH:
            begin
                mul_a      = {1'b0, acc_mag[62:32]};
                mul_b      = 32'(mag64(W'(px_reg)));
                state_next = S_PML;
            end
            S_PML:
            begin
                tmp_next   = prod_reg;
                mul_a      = acc_mag[31:0];
                mul_b      = 32'(mag64(W'(px_reg)));
                state_next = S_PADD;
            end
            S_PADD:
            begin
                if (poly_sum > (W+2)'(SAT_POS))
                    acc_next = SAT_POS;
                else if (poly_sum < (W+2)'(SAT_NEG))
                    acc_next = SAT_NEG;
                else
                    acc_next = poly_sum[W-1:0];
                if (p_reg == '0)
                    state_next = ret_reg;
                else
                begin
                    p_next     = p_reg - PW'(1);
                    state_next = S_PMH;
                end
            end
            S_F1:
            begin
                f1_next    = acc_reg;
                px_next    = x2_reg;
                acc_next   = W'(lead);
                p_next     = PW'(DEGREE - 1);
                ret_next   = S_F2;
                state_next = S_PMH;
            end
            S_F2:
            begin
                f2_next = acc_reg;
                if ((f1_reg[W-1] && acc_reg > 0) || (f1_reg > 0 && acc_reg[W-1]))
                begin
                    i_next         = '0;
                    have_prev_next = 1'b0;
                    ha_next        = mag64(f1_reg);
                    hb_next        = acc_mag;
                    state_next     = S_RHALF;
                end
                else
                begin
                    pos_next   = pos_reg + 34'(step_eff);
                    state_next = S_SCAN;
                end
            end
            S_RHALF:
            begin
                // Both magnitudes shrink together until their sum falls below 2^42.
                if (hsum >= HALF_LIM)
                begin
                    ha_next = ha_reg >> 1;
                    hb_next = hb_reg >> 1;
                end
                else
                    state_next = S_RML;
            end
            S_RML:
            begin
                mul_a      = ha_reg[31:0];
                mul_b      = w_span;
                state_next = S_RMH;
            end
            S_RMH:
            begin
                tmp_next   = prod_reg;
                mul_a      = ha_reg[63:32];
                mul_b      = w_span;
                state_next = S_RDIVS;
            end
            S_RDIVS:
            begin
                div_start  = 1'b1;
                div_num    = tmp_reg + (prod_reg << 32);
                div_den    = hsum[W-1:0];
                state_next = S_RDIV;
            end
            S_RDIV:
            begin
                if (div_done)
                begin
                    x0_next    = x1_reg + $signed(div_quo[31:0]);
                    px_next    = x1_reg + $signed(div_quo[31:0]);
                    acc_next   = W'(lead);
                    p_next     = PW'(DEGREE - 1);
                    ret_next   = S_RTEST;
                    state_next = S_PMH;
                end
            end
            S_RTEST:
            begin
                if (conv || i_reg >= lim_reg)
                begin
                    rec_en     = 1'b1;
                    rec_st     = conv ? STAT_CONVERGED : STAT_LIMIT;
                    n_next     = n_reg + NW'(1);
                    pos_next   = pos_reg + 34'(step_eff);
                    state_next = S_SCAN;
                end
                else
                begin
                    if (f0_opp)
                    begin
                        x2_next = x0_reg;
                        f2_next = acc_reg;
                        ha_next = mag64(f1_reg);
                        hb_next = acc_mag;
                    end
                    else
                    begin
                        x1_next = x0_reg;
                        f1_next = acc_reg;
                        ha_next = acc_mag;
                        hb_next = mag64(f2_reg);
                    end
                    prev_next      = x0_reg;
                    have_prev_next = 1'b1;
                    i_next         = i_reg + 10'd1;
                    state_next     = S_RHALF;
                end
            end
            S_FIN:
            begin
                if (n_reg == '0)
                begin
                    rec_en   = 1'b1;
                    rec_idx  = '0;
                    rec_root = '0;
                    rec_cnt  = '0;
                    rec_st   = STAT_NO_ROOTS;
                    n_next   = NW'(1);
                end
                state_next = S_EMIT;
            end
            S_ERR:
            begin
                rec_en     = 1'b1;
                rec_idx    = '0;
                rec_root   = '0;
                rec_cnt    = '0;
                rec_st     = STAT_BAD_BOUND;
                n_next     = NW'(1);
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (m_tready)
                begin
                    if (NW'(k_reg) == n_reg - NW'(1))
                        state_next = S_IDLE;
                    else
                        k_next = k_reg + IW'(1);
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_EMIT);
    assign m_tdata  = {6'd0, res_cnt_reg[k_reg], res_root_reg[k_reg]};
    assign m_tuser  = res_st_reg[k_reg];
    assign m_tlast  = (NW'(k_reg) == n_reg - NW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_F1;
            n_reg       <= '0;
            k_reg       <= '0;
            coef_reg[4] <= 32'sd1 <<< FRAC_BITS;
            coef_reg[3] <= '0;
            coef_reg[2] <= '0;
            coef_reg[1] <= '0;
            coef_reg[0] <= '0;
            tol_reg     <= 17'd7;
            step_reg    <= 21'd32768;
            lim_reg     <= 10'd64;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            if (cfg_we)
            begin
                priority if (cfg_addr <= REG_COEF_X0)
                    coef_reg[3'(REG_COEF_X0 - cfg_addr)] <= cfg_wdata;
                else if (cfg_addr == REG_TOLERANCE)
                    tol_reg <= cfg_wdata[16:0];
                else if (cfg_addr == REG_STEP)
                    step_reg <= cfg_wdata[20:0];
                else if (cfg_addr == REG_ITER_LIM)
                    lim_reg <= cfg_wdata[9:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q1_reg        <= q1_next;
        q2_reg        <= q2_next;
        limit_reg     <= limit_next;
        pos_reg       <= pos_next;
        x1_reg        <= x1_next;
        x2_reg        <= x2_next;
        x0_reg        <= x0_next;
        px_reg        <= px_next;
        prev_reg      <= prev_next;
        f1_reg        <= f1_next;
        f2_reg        <= f2_next;
        acc_reg       <= acc_next;
        ha_reg        <= ha_next;
        hb_reg        <= hb_next;
        tmp_reg       <= tmp_next;
        prod_reg      <= mul_p;
        p_reg         <= p_next;
        i_reg         <= i_next;
        have_prev_reg <= have_prev_next;
        if (rec_en)
        begin
            res_root_reg[rec_idx] <= rec_root;
            res_cnt_reg[rec_idx]  <= rec_cnt;
            res_st_reg[rec_idx]   <= rec_st;
        end
    end

endmodule

// ===== src/pfr_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module pfr_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [pfr_pkg::W-1:0] num,
    input  logic [pfr_pkg::W-1:0] den,
    output logic                  done,
    output logic [pfr_pkg::W-1:0] quo
);
    import pfr_pkg::*;

    localparam int CW = $clog2(W);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    rem_sh;
    logic [W:0]    rem_sub;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[W-1]};
        rem_sub   = rem_sh - {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sub[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== src/pfr_isqrt.sv =====
// Floor square root of a 64-bit value, one result bit per cycle.
module pfr_isqrt (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [pfr_pkg::W-1:0] val,
    output logic                  done,
    output logic [pfr_pkg::W-1:0] root
);
    import pfr_pkg::*;

    localparam int CW = $clog2(W / 2);

    logic [W-1:0]  v_reg, v_next;
    logic [W-1:0]  res_reg, res_next;
    logic [W-1:0]  bit_reg, bit_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W-1:0]  trial;

    always_comb
    begin
        trial     = res_reg + bit_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            v_next    = val;
            res_next  = '0;
            bit_next  = W'(1) << (W - 2);
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
                res_next = res_reg >> 1;
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(W / 2 - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg;

endmodule
